FILE: design/ledf_pkg.sv
// shared types, constants and helpers for the length-prefixed event deframer
package ledf_pkg;

  localparam int LEN_BITS_DEF    = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] MAX_TYPE_RST = 8'd5;

  localparam logic [3:0] HDR_BYTES = 4'd13;
  localparam logic [3:0] IDX_TYPE  = 4'd0;
  localparam logic [3:0] IDX_TEXT0 = 4'd1;
  localparam logic [3:0] IDX_TEXT3 = 4'd4;
  localparam logic [3:0] IDX_ERR0  = 4'd5;
  localparam logic [3:0] IDX_ERR3  = 4'd8;
  localparam logic [3:0] IDX_PAY0  = 4'd9;
  localparam logic [3:0] IDX_PAY3  = 4'd12;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_TEXT    = 5'b00010,
    PH_ERROR   = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_DONE    = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    SEC_NONE    = 2'd0,
    SEC_TEXT    = 2'd1,
    SEC_ERROR   = 2'd2,
    SEC_PAYLOAD = 2'd3
  } sec_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_SHORT_HDR   = 3'd1,
    ST_BAD_TYPE    = 3'd2,
    ST_TEXT_SHORT  = 3'd3,
    ST_ERROR_SHORT = 3'd4,
    ST_PAY_SHORT   = 3'd5,
    ST_TRAILING    = 3'd6
  } status_t;

  // one classified request on its way from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    sec_t       section;
    logic [7:0] event_type;
    logic       frame_end;
    logic       hdr_short;
    logic       text_nz;
    logic       err_nz;
    logic       pay_nz;
    logic       trailing;
  } rec_t;

  function automatic phase_t pick_phase(input logic text_nz, input logic err_nz,
                                        input logic pay_nz);
    phase_t ph;
    if (text_nz) ph = PH_TEXT;
    else if (err_nz) ph = PH_ERROR;
    else if (pay_nz) ph = PH_PAYLOAD;
    else ph = PH_DONE;
    return ph;
  endfunction

endpackage

FILE: design/ledf_front.sv
// front end: header parse, section tracking and request classification
module ledf_front #(
  parameter int LENGTH_BITS = ledf_pkg::LEN_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_data_byte,
  input  logic           in_last_byte,
  input  logic           q_full,
  output logic           push,
  output ledf_pkg::rec_t push_rec
);
  import ledf_pkg::*;

  localparam int LB = LENGTH_BITS;

  phase_t          phase_r, phase_nxt;
  logic [3:0]      hcnt_r, hcnt_nxt;
  logic [7:0]      type_r, type_nxt;
  logic [LB-1:0]   text_r, text_nxt;
  logic [LB-1:0]   err_r, err_nxt;
  logic [LB-1:0]   pay_r, pay_nxt;
  logic [LB-1:0]   acc_r, acc_nxt;
  logic            ovf_r, ovf_nxt;
  logic            trail_r, trail_nxt;

  logic            accept;
  logic            emit;
  logic            start;
  logic [LB+7:0]   wide;
  logic            ovf_all;
  logic [LB-1:0]   clamped;
  logic            text_nz, err_nz, pay_nz;
  logic [7:0]      ob;
  logic            bv;
  sec_t            sec;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    type_nxt  = type_r;
    text_nxt  = text_r;
    err_nxt   = err_r;
    pay_nxt   = pay_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    trail_nxt = trail_r;
    emit      = in_last_byte;
    ob        = 8'd0;
    bv        = 1'b0;
    sec       = SEC_NONE;

    start   = (hcnt_r == IDX_TEXT0) || (hcnt_r == IDX_ERR0) || (hcnt_r == IDX_PAY0);
    wide    = {(start ? {LB{1'b0}} : acc_r), in_data_byte};
    ovf_all = (start ? 1'b0 : ovf_r) | (wide[LB+7:LB] != 8'd0);
    clamped = ovf_all ? {LB{1'b1}} : wide[LB-1:0];

    case (phase_r)
      PH_HEADER: begin
        hcnt_nxt = hcnt_r + 4'd1;
        acc_nxt  = wide[LB-1:0];
        ovf_nxt  = ovf_all;
        if (hcnt_r == IDX_TYPE) type_nxt = in_data_byte;
        if (hcnt_r == IDX_TEXT3) text_nxt = clamped;
        if (hcnt_r == IDX_ERR3) err_nxt = clamped;
        if (hcnt_r == IDX_PAY3) pay_nxt = clamped;
      end
      PH_TEXT: begin
        emit     = 1'b1;
        ob       = in_data_byte;
        bv       = 1'b1;
        sec      = SEC_TEXT;
        text_nxt = text_r - LB'(1);
      end
      PH_ERROR: begin
        emit    = 1'b1;
        ob      = in_data_byte;
        bv      = 1'b1;
        sec     = SEC_ERROR;
        err_nxt = err_r - LB'(1);
      end
      PH_PAYLOAD: begin
        emit    = 1'b1;
        ob      = in_data_byte;
        bv      = 1'b1;
        sec     = SEC_PAYLOAD;
        pay_nxt = pay_r - LB'(1);
      end
      PH_DONE: begin
        trail_nxt = 1'b1;
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase

    text_nz = (text_nxt != '0);
    err_nz  = (err_nxt != '0);
    pay_nz  = (pay_nxt != '0);

    if ((phase_r == PH_HEADER && hcnt_r == IDX_PAY3) || phase_r == PH_TEXT ||
        phase_r == PH_ERROR || phase_r == PH_PAYLOAD) begin
      phase_nxt = pick_phase(text_nz, err_nz, pay_nz);
    end

    push_rec.data       = ob;
    push_rec.byte_valid = bv;
    push_rec.section    = sec;
    push_rec.event_type = type_nxt;
    push_rec.frame_end  = in_last_byte;
    push_rec.hdr_short  = (hcnt_nxt < HDR_BYTES);
    push_rec.text_nz    = text_nz;
    push_rec.err_nz     = err_nz;
    push_rec.pay_nz     = pay_nz;
    push_rec.trailing   = trail_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_last_byte)) begin
      phase_r <= PH_HEADER;
      hcnt_r  <= 4'd0;
      type_r  <= 8'd0;
      text_r  <= '0;
      err_r   <= '0;
      pay_r   <= '0;
      acc_r   <= '0;
      ovf_r   <= 1'b0;
      trail_r <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      type_r  <= type_nxt;
      text_r  <= text_nxt;
      err_r   <= err_nxt;
      pay_r   <= pay_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      trail_r <= trail_nxt;
    end
  end

endmodule

FILE: design/ledf_queue.sv
// small request queue between front and back
module ledf_queue #(
  parameter int DEPTH = ledf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  ledf_pkg::rec_t wr_rec,
  output logic           full,
  output logic           rd_valid,
  input  logic           rd_en,
  output ledf_pkg::rec_t rd_rec
);
  import ledf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rec_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_wr, do_rd;

  assign full     = (count_r == CW'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;
  assign rd_rec   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    case ({do_wr, do_rd})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_nxt;
      if (do_rd) rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

FILE: design/ledf_back.sv
// back end: type limit register, frame verdict and output register
module ledf_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [7:0]     cfg_data,
  input  logic           q_valid,
  output logic           q_pop,
  input  ledf_pkg::rec_t q_rec,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           out_byte_valid,
  output logic [1:0]     out_section,
  output logic [7:0]     out_event_type,
  output logic           out_frame_end,
  output logic [2:0]     out_status
);
  import ledf_pkg::*;

  logic [7:0] max_type_r;
  logic       out_valid_r;
  logic [7:0] byte_r;
  logic       bv_r;
  sec_t       sec_r;
  logic [7:0] type_r;
  logic       end_r;
  status_t    status_r, status_nxt;
  logic       load;

  assign cfg_ready = 1'b1;
  assign load      = q_valid && (!out_valid_r || out_ready);
  assign q_pop     = load;

  always_comb begin
    if (!q_rec.frame_end) status_nxt = ST_OK;
    else if (q_rec.hdr_short) status_nxt = ST_SHORT_HDR;
    else if (q_rec.event_type > max_type_r) status_nxt = ST_BAD_TYPE;
    else if (q_rec.text_nz) status_nxt = ST_TEXT_SHORT;
    else if (q_rec.err_nz) status_nxt = ST_ERROR_SHORT;
    else if (q_rec.pay_nz) status_nxt = ST_PAY_SHORT;
    else if (q_rec.trailing) status_nxt = ST_TRAILING;
    else status_nxt = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_type_r  <= MAX_TYPE_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) max_type_r <= cfg_data;
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= q_rec.data;
      bv_r     <= q_rec.byte_valid;
      sec_r    <= q_rec.section;
      type_r   <= q_rec.event_type;
      end_r    <= q_rec.frame_end;
      status_r <= status_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = byte_r;
  assign out_byte_valid = bv_r;
  assign out_section    = sec_r;
  assign out_event_type = type_r;
  assign out_frame_end  = end_r;
  assign out_status     = status_r;

endmodule

FILE: design/length_prefixed_event_deframer_top.sv
// Length-prefixed event deframer. Takes one frame byte per cycle, sustained, with no
// bubbles: a 13-byte header (type, then big-endian text, error and payload lengths)
// followed by body bytes that come out tagged with their section. Header and trailing
// bytes give a result only when they close the frame; the frame verdict rides on the
// result for the last byte. A byte's result goes from the front parse into the request
// queue, then into the output register, before it is offered. The input stalls
// only when the request queue (QUEUE_DEPTH entries) is full because the result side
// is holding off. max_type_code is written through the cfg port, resets to 5, and
// must be changed only while no frame is in flight.
module length_prefixed_event_deframer_top #(
  parameter int LENGTH_BITS = ledf_pkg::LEN_BITS_DEF,
  parameter int QUEUE_DEPTH = ledf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic [1:0] out_section,
  output logic [7:0] out_event_type,
  output logic       out_frame_end,
  output logic [2:0] out_status
);
  import ledf_pkg::*;

  logic push, q_full, q_valid, q_pop;
  rec_t push_rec, q_rec;

  ledf_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .push         (push),
    .push_rec     (push_rec)
  );

  ledf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_rec   (push_rec),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_en    (q_pop),
    .rd_rec   (q_rec)
  );

  ledf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_rec          (q_rec),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_section    (out_section),
    .out_event_type (out_event_type),
    .out_frame_end  (out_frame_end),
    .out_status     (out_status)
  );

endmodule

FILE: design/ledf_checker.sv
// port-level checks for the deframer, bound to the top level
module ledf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic [1:0] out_section,
  input logic [7:0] out_event_type,
  input logic       out_frame_end,
  input logic [2:0] out_status
);
  import ledf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_status) &&
      $stable(out_event_type) && $stable(out_frame_end))
    else $error("result changed while stalled");

  a_nonbody: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_byte == 8'd0 && out_section == SEC_NONE &&
      out_frame_end)
    else $error("non-body result without frame end or with data");

  a_body_sec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_valid |-> out_section != SEC_NONE)
    else $error("body byte without section");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (!out_frame_end || out_byte_valid) |-> out_status <= ST_TRAILING &&
      (out_frame_end || out_status == ST_OK))
    else $error("status outside frame end");

endmodule

bind length_prefixed_event_deframer_top ledf_checker u_ledf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_byte       (out_byte),
  .out_byte_valid (out_byte_valid),
  .out_section    (out_section),
  .out_event_type (out_event_type),
  .out_frame_end  (out_frame_end),
  .out_status     (out_status)
);
